FILE: hdl/bbla_pkg.sv
// Shared types and constants for the block buffer lookup/allocate directory.
// Used by bbla_frame_ram and block_buffer_lookup_allocate; no dependencies.
`default_nettype none

package bbla_pkg;

    localparam int TAG_W    = 40;
    localparam int REF_W    = 16;
    localparam int OFFSET_W = 45;
    localparam int FRAME_W  = 8;
    localparam int BLOCK_W  = 32;
    localparam int TABLE_W  = 8;
    localparam int STATUS_W = 3;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    // Request operation codes
    localparam logic OP_BORROW = 1'b0;
    localparam logic OP_MARK   = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MARKED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC  = 3'd4;

    typedef struct packed {
        logic                operation;
        logic [TABLE_W-1:0]  table_id;
        logic [BLOCK_W-1:0]  block_id;
        logic [FRAME_W-1:0]  frame_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic [REF_W-1:0]    ref_count;
        logic [OFFSET_W-1:0] read_offset;
    } rsp_t;

    // One directory entry: dirty bit, reference count and block tag
    typedef struct packed {
        logic              dirty;
        logic [REF_W-1:0]  refs;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/block_buffer_lookup_allocate.sv
// Top level of the buffer-frame directory: sequencer, tag scan and response register.
// Depends on bbla_pkg and bbla_frame_ram.
//
// A fully associative directory of FRAMES buffer frames. A borrow word looks
// up {table_id, block_id} by walking the allocated frames one per cycle
// through a frame memory with one write port and one read port. A hit bumps the
// saturating reference count, a miss takes the next free frame from the top
// index down and reports the file offset to load (0 for block 0, else
// block_id * BLOCK_BYTES + SUPER_BYTES). A mark-written word steps through
// read, write back and respond, or only respond when the frame is not
// allocated. Only one request is in flight at a time; req_stall is high
// while a request is being worked. The finished response sits in an output
// register, so a new request is taken while it waits.
// Frame contents are undefined until allocated; no clearing pass is needed.
`default_nettype none

module block_buffer_lookup_allocate #(
    parameter int FRAMES      = 256,
    parameter int BLOCK_BYTES = 4096,
    parameter int SUPER_BYTES = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire bbla_pkg::req_t req_word,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output bbla_pkg::rsp_t      rsp_word
);
    import bbla_pkg::*;

    localparam int FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW   = $clog2(FRAMES + 1);
    localparam int CMPW = (CW > FRAME_W) ? CW : FRAME_W;
    localparam int PW   = BLOCK_W + $clog2(BLOCK_BYTES + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MARK_RD = 3'd1;
    localparam logic [2:0] S_MARK_WR = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_MISS    = 3'd4;
    localparam logic [2:0] S_OFFSET  = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    // Control registers
    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  issue_reg, issue_next;
    logic           cmp_vld_reg, cmp_vld_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Payload registers
    logic [FW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [BLOCK_W-1:0] block_reg, block_next;
    logic [FW-1:0]      fidx_reg, fidx_next;
    logic [PW-1:0]      prod_reg, prod_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;

    // Frame memory port signals
    logic          mem_we;
    logic [FW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [FW-1:0] mem_raddr;
    entry_t        mem_rdata;

    // Mark-written allocation check
    logic [CMPW-1:0] mark_idx_c;
    logic [CMPW-1:0] frames_c;
    logic [CMPW-1:0] first_c;
    logic            mark_alloc;
    logic            scan_hit;
    logic [FW-1:0]   alloc_idx;

    bbla_frame_ram #(
        .DEPTH  (FRAMES),
        .ADDR_W (FW)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign mark_idx_c = CMPW'(req_word.frame_index);
    assign frames_c   = CMPW'(FRAMES);
    assign first_c    = frames_c - CMPW'(used_reg);
    assign mark_alloc = (mark_idx_c < frames_c) && (mark_idx_c >= first_c);
    assign scan_hit   = cmp_vld_reg && (mem_rdata.tag == tag_reg);
    assign alloc_idx  = FW'(CW'(FRAMES - 1) - used_reg);

    // Sequencer and shared tag comparator
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        tag_next       = tag_reg;
        block_next     = block_reg;
        fidx_next      = fidx_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = fidx_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = fidx_reg;

        // Drop the response once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    tag_next   = {req_word.table_id, req_word.block_id};
                    block_next = req_word.block_id;
                    fidx_next  = FW'(req_word.frame_index);
                    if (req_word.operation == OP_MARK)
                    begin
                        if (mark_alloc)
                        begin
                            state_next = S_MARK_RD;
                        end
                        else
                        begin
                            res_next.status      = ST_NOT_ALLOC;
                            res_next.frame       = req_word.frame_index;
                            res_next.ref_count   = '0;
                            res_next.read_offset = '0;
                            state_next           = S_FIN;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        issue_next = CW'(FRAMES) - used_reg;
                        state_next = S_SCAN;
                    end
                end
            end

            S_MARK_RD:
            begin
                // Read address is fidx_reg; data lands next cycle
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                mem_we               = 1'b1;
                mem_wdata.dirty      = 1'b1;
                res_next.status      = ST_MARKED;
                res_next.frame       = FRAME_W'(fidx_reg);
                res_next.ref_count   = mem_rdata.refs;
                res_next.read_offset = '0;
                state_next           = S_FIN;
            end

            S_SCAN:
            begin
                // Issue the next tag read
                mem_raddr = issue_reg[FW-1:0];
                if (issue_reg < CW'(FRAMES))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[FW-1:0];
                    issue_next   = issue_reg + 1'b1;
                end
                // Compare the tag read last cycle
                if (scan_hit)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = cmp_idx_reg;
                    if (mem_rdata.refs != REF_MAX)
                    begin
                        mem_wdata.refs = mem_rdata.refs + 1'b1;
                    end
                    res_next.status      = ST_HIT;
                    res_next.frame       = FRAME_W'(cmp_idx_reg);
                    res_next.ref_count   = mem_wdata.refs;
                    res_next.read_offset = '0;
                    cmp_vld_next         = 1'b0;
                    state_next           = S_FIN;
                end
                else if (issue_reg >= CW'(FRAMES))
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_MISS;
                end
            end

            S_MISS:
            begin
                if (used_reg == CW'(FRAMES))
                begin
                    res_next.status      = ST_NO_FRAMES;
                    res_next.frame       = '0;
                    res_next.ref_count   = '0;
                    res_next.read_offset = '0;
                    state_next           = S_FIN;
                end
                else
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = alloc_idx;
                    mem_wdata.dirty    = 1'b0;
                    mem_wdata.refs     = REF_W'(1);
                    mem_wdata.tag      = tag_reg;
                    used_next          = used_reg + 1'b1;
                    prod_next          = PW'(block_reg) * PW'(BLOCK_BYTES);
                    res_next.status    = ST_MISS;
                    res_next.frame     = FRAME_W'(alloc_idx);
                    res_next.ref_count = REF_W'(1);
                    state_next         = S_OFFSET;
                end
            end

            S_OFFSET:
            begin
                if (block_reg == '0)
                begin
                    res_next.read_offset = '0;
                end
                else
                begin
                    res_next.read_offset = OFFSET_W'(prod_reg) + OFFSET_W'(SUPER_BYTES);
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                // Hand over to the output register when it is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        tag_reg     <= tag_next;
        block_reg   <= block_next;
        fidx_reg    <= fidx_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

`default_nettype wire

FILE: hdl/bbla_frame_ram.sv
// Frame directory storage: one write port, one registered read port.
// Depends on bbla_pkg for the entry type.
`default_nettype none

module bbla_frame_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    waddr,
    input  wire bbla_pkg::entry_t     wdata,
    input  wire logic [ADDR_W-1:0]    raddr,
    output bbla_pkg::entry_t          rdata
);
    import bbla_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write one entry, read one entry each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
